// ----- hdl/dsq_pkg.sv -----
// ----------------------------------------------------------------------------
// dsq_pkg
// Types and constants shared by the disk request sequencer modules.
// ----------------------------------------------------------------------------
package dsq_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT = 2'd2;

   localparam logic [15:0] BLOCK_LIMIT_RST = 16'd1232;
   localparam logic [2:0]  UNIT_LIMIT_RST  = 3'd2;
   localparam logic [3:0]  RETRY_LIMIT_RST = 4'd10;

   // per-sector advance
   localparam logic [15:0] WCOUNT_STEP = 16'd256;
   localparam logic [15:0] ADDR_STEP   = 16'd512;

   // result kinds
   localparam logic KIND_CMD  = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam int EVQ_DEPTH = 2;

   typedef enum logic [1:0] {
      EV_SUBMIT,
      EV_REJECT,
      EV_COMPLETE
   } ev_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_LOAD
   } back_state_type;

   // classified item handed from front to back
   typedef struct packed {
      ev_kind_type  kind;
      logic [7:0]   tag;
      logic [1:0]   unit;
      logic [15:0]  block;
      logic [15:0]  wcount;
      logic         rd;
      logic [15:0]  addr;
      logic         err;
   } ev_type;

   // one result
   typedef struct packed {
      logic         kind;
      logic [7:0]   tag;
      logic [1:0]   unit;
      logic [3:0]   sector;
      logic [6:0]   track;
      logic         rd;
      logic [15:0]  addr;
      logic         failed;
      logic         last;
   } rsp_type;

endpackage

// ----- hdl/disk_request_sequencer.sv -----
// ----------------------------------------------------------------------------
// disk_request_sequencer
// Queues disk transfer requests and sequences per-sector commands, retries
// and finish reports from controller completions.
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_ready   cmd, tag, unit, block, count,
//                                                 direction, address, error
//   rsp_      out         rsp_valid / rsp_ready   kind, tag, command, failed, last
//   csr_      in          csr_valid / csr_ready   index, write data
//
// A request enters the event queue as a registered entry and the back end
// takes it from there; a finished request hands over to the next queued one
// through the BK_READ and BK_LOAD states (registered FIFO read), and each
// result is held in the result register. Up to two requests wait in the
// event queue while the result side stalls. No clearing pass after reset;
// the block is ready right out of reset. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module disk_request_sequencer import dsq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [7:0]           req_req_tag,
   input  logic [2:0]           req_drive_unit,
   input  logic [15:0]          req_start_block,
   input  logic signed [15:0]   req_word_count,
   input  logic                 req_is_read,
   input  logic [15:0]          req_mem_address,
   input  logic                 req_ctrl_error,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [7:0]           rsp_out_tag,
   output logic [1:0]           rsp_out_unit,
   output logic [3:0]           rsp_sector,
   output logic [6:0]           rsp_track,
   output logic                 rsp_out_read,
   output logic [15:0]          rsp_out_address,
   output logic                 rsp_failed,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   logic       evq_full, ev_push, ev_pop, ev_valid;
   ev_type     ev_in, ev_head;
   logic [3:0] retry_limit;
   rsp_type    rsp;

   dsq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_req_tag     (req_req_tag),
      .req_drive_unit  (req_drive_unit),
      .req_start_block (req_start_block),
      .req_word_count  (req_word_count),
      .req_is_read     (req_is_read),
      .req_mem_address (req_mem_address),
      .req_ctrl_error  (req_ctrl_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .evq_full        (evq_full),
      .ev_push         (ev_push),
      .ev_out          (ev_in),
      .retry_limit     (retry_limit)
   );

   dsq_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_in),
      .full      (evq_full),
      .pop       (ev_pop),
      .valid     (ev_valid),
      .head      (ev_head)
   );

   dsq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .ev_valid    (ev_valid),
      .ev          (ev_head),
      .ev_pop      (ev_pop),
      .retry_limit (retry_limit),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   assign rsp_kind        = rsp.kind;
   assign rsp_out_tag     = rsp.tag;
   assign rsp_out_unit    = rsp.unit;
   assign rsp_sector      = rsp.sector;
   assign rsp_track       = rsp.track;
   assign rsp_out_read    = rsp.rd;
   assign rsp_out_address = rsp.addr;
   assign rsp_failed      = rsp.failed;
   assign rsp_last        = rsp.last;

endmodule

// ----- hdl/dsq_front.sv -----
// ----------------------------------------------------------------------------
// dsq_front
// Accepts requests, holds the limit registers and classifies each request
// as submit, reject or completion before handing it to the event queue.
// ----------------------------------------------------------------------------
module dsq_front import dsq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [7:0]           req_req_tag,
   input  logic [2:0]           req_drive_unit,
   input  logic [15:0]          req_start_block,
   input  logic signed [15:0]   req_word_count,
   input  logic                 req_is_read,
   input  logic [15:0]          req_mem_address,
   input  logic                 req_ctrl_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic                 evq_full,
   output logic                 ev_push,
   output ev_type               ev_out,
   output logic [3:0]           retry_limit
);

   logic [15:0] block_limit_ff, block_limit_in;
   logic [2:0]  unit_limit_ff, unit_limit_in;
   logic [3:0]  retry_limit_ff, retry_limit_in;
   logic        csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   always_comb begin
      block_limit_in = block_limit_ff;
      unit_limit_in  = unit_limit_ff;
      retry_limit_in = retry_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_LIMIT: block_limit_in = csr_wdata;
            CSR_UNIT_LIMIT:  unit_limit_in  = csr_wdata[2:0];
            CSR_RETRY_LIMIT: retry_limit_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_limit_ff <= BLOCK_LIMIT_RST;
         unit_limit_ff  <= UNIT_LIMIT_RST;
         retry_limit_ff <= RETRY_LIMIT_RST;
      end else begin
         block_limit_ff <= block_limit_in;
         unit_limit_ff  <= unit_limit_in;
         retry_limit_ff <= retry_limit_in;
      end
   end

   assign retry_limit = retry_limit_ff;
   assign req_ready   = ~evq_full;
   assign ev_push     = req_valid & req_ready;

   always_comb begin
      ev_out.tag    = req_req_tag;
      ev_out.unit   = req_drive_unit[1:0];
      ev_out.block  = req_start_block;
      ev_out.wcount = req_word_count;
      ev_out.rd     = req_is_read;
      ev_out.addr   = req_mem_address;
      ev_out.err    = req_ctrl_error;
      priority if (req_cmd)
         ev_out.kind = EV_COMPLETE;
      else if (req_start_block >= block_limit_ff || req_drive_unit >= unit_limit_ff)
         ev_out.kind = EV_REJECT;
      else
         ev_out.kind = EV_SUBMIT;
   end

endmodule

// ----- hdl/dsq_evq.sv -----
// ----------------------------------------------------------------------------
// dsq_evq
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module dsq_evq import dsq_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  ev_type push_data,
   output logic   full,
   input  logic   pop,
   output logic   valid,
   output ev_type head
);

   ev_type      slot_ff [EVQ_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_pop;

   assign valid  = (count_ff != 2'd0);
   assign full   = (count_ff == 2'(EVQ_DEPTH));
   assign head   = slot_ff[rd_ptr_ff];
   assign do_pop = pop & valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- hdl/dsq_back.sv -----
// ----------------------------------------------------------------------------
// dsq_back
// Request FIFO, head request registers, retry bookkeeping and the result
// register. Carries out one classified request at a time.
// ----------------------------------------------------------------------------
module dsq_back import dsq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       ev_valid,
   input  ev_type     ev,
   output logic       ev_pop,
   input  logic [3:0] retry_limit,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  tag;
      logic [1:0]  unit;
      logic [15:0] block;
      logic [15:0] wcount;
      logic        rd;
      logic [15:0] addr;
   } entry_type;

   entry_type      mem [QUEUE_DEPTH];
   entry_type      rd_data_ff;
   entry_type      wr_data;
   logic           mem_we;

   back_state_type state_ff, state_in;
   logic [PTR_W-1:0] head_ptr_ff, head_ptr_in, tail_ptr_ff, tail_ptr_in;
   logic [PTR_W-1:0] head_inc, tail_inc;
   logic [CNT_W-1:0] count_ff, count_in;
   logic           busy_ff, busy_in;
   logic [3:0]     retry_ff, retry_in;
   logic           hfail_ff, hfail_in;
   entry_type      hd_ff, hd_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_load;

   logic           slot_free, q_full, retry_ok, last_entry, sector_done, pop_next;
   logic [15:0]    wc_next;

   function automatic rsp_type make_cmd(entry_type e);
      rsp_type r;
      r.kind   = KIND_CMD;
      r.tag    = e.tag;
      r.unit   = e.unit;
      r.sector = e.block[3:0];
      r.track  = e.block[10:4];
      r.rd     = e.rd;
      r.addr   = e.addr;
      r.failed = 1'b0;
      r.last   = 1'b1;
      return r;
   endfunction

   function automatic rsp_type make_done(logic [7:0] tag, logic failed, logic last);
      rsp_type r;
      r        = '0;
      r.kind   = KIND_DONE;
      r.tag    = tag;
      r.failed = failed;
      r.last   = last;
      return r;
   endfunction

   assign slot_free   = ~rsp_valid_ff | rsp_ready;
   assign q_full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign retry_ok    = (retry_ff < retry_limit);
   assign last_entry  = (count_ff == CNT_W'(1));
   assign wc_next     = hd_ff.wcount + WCOUNT_STEP;
   assign sector_done = (wc_next == 16'd0);
   assign head_inc    = (head_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ptr_ff + PTR_W'(1);
   assign tail_inc    = (tail_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr_ff + PTR_W'(1);

   // completion that finishes the head while another request waits behind it
   assign pop_next = ev_valid & slot_free & (ev.kind == EV_COMPLETE) & busy_ff &
                     ~(ev.err & retry_ok) & sector_done & ~last_entry;

   always_comb begin
      wr_data.tag    = ev.tag;
      wr_data.unit   = ev.unit;
      wr_data.block  = ev.block;
      wr_data.wcount = ev.wcount;
      wr_data.rd     = ev.rd;
      wr_data.addr   = ev.addr;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (pop_next) state_in = BK_READ;
         BK_READ: state_in = BK_LOAD;
         BK_LOAD: if (slot_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_ptr_in = head_ptr_ff;
      tail_ptr_in = tail_ptr_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      retry_in    = retry_ff;
      hfail_in    = hfail_ff;
      hd_in       = hd_ff;
      rsp_in      = rsp_ff;
      rsp_load    = 1'b0;
      mem_we      = 1'b0;
      ev_pop      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (ev_valid && slot_free) begin
               ev_pop = ~pop_next;
               unique case (ev.kind)
                  EV_REJECT: begin
                     rsp_load = 1'b1;
                     rsp_in   = make_done(ev.tag, 1'b1, 1'b1);
                  end
                  EV_SUBMIT: begin
                     if (q_full) begin
                        rsp_load = 1'b1;
                        rsp_in   = make_done(ev.tag, 1'b1, 1'b1);
                     end else begin
                        mem_we      = 1'b1;
                        tail_ptr_in = tail_inc;
                        count_in    = count_ff + CNT_W'(1);
                        if (!busy_ff) begin
                           // queue was empty: the new request is the head
                           busy_in  = 1'b1;
                           hd_in    = wr_data;
                           rsp_load = 1'b1;
                           rsp_in   = make_cmd(wr_data);
                        end
                     end
                  end
                  EV_COMPLETE: begin
                     if (busy_ff) begin
                        if (ev.err && retry_ok) begin
                           retry_in = retry_ff + 4'd1;
                           rsp_load = 1'b1;
                           rsp_in   = make_cmd(hd_ff);
                        end else begin
                           retry_in = 4'd0;
                           if (sector_done) begin
                              rsp_load    = 1'b1;
                              rsp_in      = make_done(hd_ff.tag, hfail_ff | ev.err,
                                                      last_entry);
                              hfail_in    = 1'b0;
                              head_ptr_in = head_inc;
                              count_in    = count_ff - CNT_W'(1);
                              if (last_entry) busy_in = 1'b0;
                           end else begin
                              hfail_in     = hfail_ff | ev.err;
                              hd_in.wcount = wc_next;
                              hd_in.block  = hd_ff.block + 16'd1;
                              hd_in.addr   = hd_ff.addr + ADDR_STEP;
                              rsp_load     = 1'b1;
                              rsp_in       = make_cmd(hd_in);
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_READ: ;
         BK_LOAD: begin
            if (slot_free) begin
               ev_pop   = 1'b1;
               hd_in    = rd_data_ff;
               rsp_load = 1'b1;
               rsp_in   = make_cmd(rd_data_ff);
            end
         end
         default: ;
      endcase
      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ptr_ff  <= '0;
         tail_ptr_ff  <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         retry_ff     <= 4'd0;
         hfail_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         retry_ff     <= retry_in;
         hfail_ff     <= hfail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hd_ff  <= hd_in;
      rsp_ff <= rsp_in;
   end

   // request FIFO storage, read port follows the head pointer
   always_ff @(posedge clock) begin
      if (mem_we)
         mem[tail_ptr_ff] <= wr_data;
      rd_data_ff <= mem[head_ptr_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- hdl/dsq_chk.sv -----
// ----------------------------------------------------------------------------
// dsq_chk
// Port-level checks on the result channel of the disk request sequencer.
// ----------------------------------------------------------------------------
module dsq_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_out_tag,
   input logic [1:0]  rsp_out_unit,
   input logic [3:0]  rsp_sector,
   input logic [6:0]  rsp_track,
   input logic        rsp_out_read,
   input logic [15:0] rsp_out_address,
   input logic        rsp_failed,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before accept");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_tag) && $stable(rsp_kind) &&
                                  $stable(rsp_last))
      else $error("stalled result changed");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_out_unit == 2'd0 && rsp_sector == 4'd0 &&
                                rsp_track == 7'd0 && !rsp_out_read &&
                                rsp_out_address == 16'd0)
      else $error("finish result carries command fields");

   a_cmd_not_failed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> !rsp_failed)
      else $error("command result flagged failed");

   // a command result always carries the last flag
   a_cmd_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_last)
      else $error("command result not last");

endmodule

bind disk_request_sequencer dsq_chk u_dsq_chk (.*);
